// ===== sv/lrh_pkg.sv =====
// ----------------------------------------------------------------------------
// lrh_pkg
// Shared widths, pipeline depths and lane result type for the reconciliation
// hint block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrh_pkg;

  // Block shape
  localparam int LANES   = 4;
  localparam int COEF_W  = 16;
  localparam int MOD_W   = 15;
  localparam int HINT_W  = 8;

  // Scaling: t * 2^QSHIFT + modulus/2, 20-bit signed numerator
  localparam int QSHIFT  = 3;
  localparam int NUM_W   = COEF_W + QSHIFT + 1;
  localparam int MAG_W   = NUM_W - 1;

  // Only the low bucket bits (coarse + fine) are visible
  localparam int BKT_LOW_W = 3;
  localparam int BKT_TOP_W = 1;
  localparam int BUCKET_W  = BKT_LOW_W + BKT_TOP_W;

  // One quotient bit per divider stage, plus correction and numerator stages
  localparam int DIV_STAGES = MAG_W;
  localparam int PIPE_DEPTH = DIV_STAGES + 2;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic [BUCKET_W-1:0] scaled;  // low bits of the signed scaled value
    logic                par;     // LSB of the corrected coefficient
  } lane_out_t;

endpackage

`default_nettype wire

// ===== sv/lattice_reconcile_hint.sv =====
// Pipeline: an accepted in_ beat passes the correction stage, numerator stage,
//   19 divider stages and output register before out_tvalid rises.
// Throughput: one block per cycle while in_tready is high; the four lanes divide side by side.
// Backpressure: a skid slot behind the output register lets one more result
//   land; in_tready drops only while that slot is full.
// Reset (rst_n, synchronous, active low): pipeline and output empty, modulus = 3329.
// ----------------------------------------------------------------------------
// lattice_reconcile_hint
// Top level: configuration register, four coefficient lanes, valid pipeline
// and the merge stage that builds the hint byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_reconcile_hint (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Configuration: modulus
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [lrh_pkg::MOD_W-1:0] cfg_data,
  // Input stream
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [63:0]               in_tdata,   // coef_0, coef_1, coef_2, coef_3
  // Result stream
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [lrh_pkg::HINT_W-1:0]     out_tdata   // hint_byte
);

  localparam int PD = lrh_pkg::PIPE_DEPTH;
  localparam int CW = lrh_pkg::COEF_W;
  localparam logic [lrh_pkg::MOD_W-1:0] MOD_RESET = lrh_pkg::MOD_W'(3329);

  logic [lrh_pkg::MOD_W-1:0] modulus_r;
  logic                      v_r [PD];
  logic                      en;
  lrh_pkg::lane_out_t        lane_res [lrh_pkg::LANES];

  // Modulus register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (cfg_valid) begin
      modulus_r <= cfg_data;
    end
  end

  // Accept whenever the pipeline can advance
  assign in_tready = en;

  // Valid bits travel alongside the lane payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < PD; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int s = 1; s < PD; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  // Four lanes, one per coefficient
  for (genvar l = 0; l < lrh_pkg::LANES; l++) begin : g_lane
    lrh_lane u_lane (
      .clk     (clk),
      .en      (en),
      .modulus (modulus_r),
      .coef    (in_tdata[l*CW +: CW]),
      .result  (lane_res[l])
    );
  end

  lrh_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .modulus    (modulus_r),
    .up_valid   (v_r[PD-1]),
    .up_ready   (en),
    .lane_res   (lane_res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef NO_ASSERTIONS
  // An accepted beat enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted beat missing from first stage");

  // A stalled pipeline keeps its finished item
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en && v_r[PD-1] |=> v_r[PD-1])
    else $error("last stage item lost during stall");

  // A result is withdrawn only after it was taken
  a_out_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_tvalid) |-> $past(out_tready))
    else $error("result dropped without handshake");
`endif

endmodule

`default_nettype wire

// ===== sv/lrh_lane.sv =====
// ----------------------------------------------------------------------------
// lrh_lane
// One coefficient lane: negative correction, scaled numerator and a
// pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lrh_lane (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [lrh_pkg::MOD_W-1:0]         modulus,
  input  wire logic signed [lrh_pkg::COEF_W-1:0] coef,
  output lrh_pkg::lane_out_t                     result
);

  localparam int DS = lrh_pkg::DIV_STAGES;
  localparam int MW = lrh_pkg::MOD_W;
  localparam int AW = lrh_pkg::MAG_W;
  localparam int NW = lrh_pkg::NUM_W;
  localparam int BW = lrh_pkg::BUCKET_W;

  // Stage 1: corrected coefficient
  logic [lrh_pkg::COEF_W-1:0] t_r, t_nxt;

  // Stage 2: numerator magnitude and sign
  logic [NW-1:0] num;
  logic [AW-1:0] mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic          par2_r;

  // Divider stages
  logic [MW-1:0] rem_r [DS];
  logic [AW-1:0] dvd_r [DS];
  logic [BW-1:0] qb_r  [DS];
  logic          sgn_r [DS];
  logic          par_r [DS];

  logic [MW-1:0] rem_nxt [DS];
  logic [AW-1:0] dvd_nxt [DS];
  logic [BW-1:0] qb_nxt  [DS];

  // Add the modulus once to a negative coefficient, wrap to 16 bits
  always_comb begin
    if (coef[lrh_pkg::COEF_W-1]) begin
      t_nxt = coef + {1'b0, modulus};
    end else begin
      t_nxt = coef;
    end
  end

  // Numerator t*8 + modulus/2, then split into sign and magnitude
  always_comb begin
    num     = {t_r[lrh_pkg::COEF_W-1], t_r, {lrh_pkg::QSHIFT{1'b0}}}
              + {{(NW - MW + 1){1'b0}}, modulus[MW-1:1]};
    neg_nxt = num[NW-1];
    if (num[NW-1]) begin
      mag_nxt = AW'(-num);
    end else begin
      mag_nxt = num[AW-1:0];
    end
  end

  // Restoring step per stage: shift in the next dividend bit, subtract if it fits
  always_comb begin
    logic [MW-1:0] rem_in;
    logic [AW-1:0] dvd_in;
    logic [BW-1:0] qb_in;
    logic [MW:0]   trial;
    logic          fit;
    rem_in = '0;
    dvd_in = mag_r;
    qb_in  = '0;
    for (int s = 0; s < DS; s++) begin
      trial      = {rem_in, dvd_in[AW-1]};
      fit        = (trial >= {1'b0, modulus});
      rem_nxt[s] = fit ? MW'(trial - {1'b0, modulus}) : trial[MW-1:0];
      dvd_nxt[s] = {dvd_in[AW-2:0], 1'b0};
      qb_nxt[s]  = {qb_in[BW-2:0], fit};
      // The next stage works on what this stage holds
      rem_in = rem_r[s];
      dvd_in = dvd_r[s];
      qb_in  = qb_r[s];
    end
  end

  // Advance the whole lane together
  always_ff @(posedge clk) begin
    if (en) begin
      t_r      <= t_nxt;
      mag_r    <= mag_nxt;
      neg_r    <= neg_nxt;
      par2_r   <= t_r[0];
      sgn_r[0] <= neg_r;
      par_r[0] <= par2_r;
      for (int s = 0; s < DS; s++) begin
        rem_r[s] <= rem_nxt[s];
        dvd_r[s] <= dvd_nxt[s];
        qb_r[s]  <= qb_nxt[s];
      end
      for (int s = 1; s < DS; s++) begin
        sgn_r[s] <= sgn_r[s-1];
        par_r[s] <= par_r[s-1];
      end
    end
  end

  // Truncating division: negate the quotient when the numerator was negative
  always_comb begin
    if (sgn_r[DS-1]) begin
      result.scaled = BW'(~qb_r[DS-1] + 1'b1);
    end else begin
      result.scaled = qb_r[DS-1];
    end
    result.par = par_r[DS-1];
  end

endmodule

`default_nettype wire

// ===== sv/lrh_merge.sv =====
// ----------------------------------------------------------------------------
// lrh_merge
// Sums the lane buckets, packs the hint byte and holds it in an output
// register with a skid slot behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module lrh_merge (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [lrh_pkg::MOD_W-1:0] modulus,
  input  wire logic                      up_valid,
  output logic                           up_ready,
  input  wire lrh_pkg::lane_out_t        lane_res [lrh_pkg::LANES],
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [lrh_pkg::HINT_W-1:0]     out_tdata
);

  localparam int BW = lrh_pkg::BUCKET_W;
  localparam int HW = lrh_pkg::HINT_W;

  logic [BW-1:0] bucket;
  logic [HW-1:0] hint;
  logic          up_fire;
  logic          out_free;

  logic          out_v_r, out_v_nxt;
  logic [HW-1:0] out_d_r, out_d_nxt;
  logic          skid_v_r, skid_v_nxt;
  logic [HW-1:0] skid_d_r, skid_d_nxt;

  // Sum the scaled values modulo the visible bucket width; no divisor means zero
  always_comb begin
    bucket = '0;
    for (int l = 0; l < lrh_pkg::LANES; l++) begin
      bucket = bucket + lane_res[l].scaled;
    end
    if (modulus == '0) begin
      bucket = '0;
    end
  end

  // Pair sum and difference share the same parity: a0 ^ b0
  assign hint = {lane_res[2].par ^ lane_res[3].par, lane_res[2].par ^ lane_res[3].par,
                 lane_res[0].par ^ lane_res[1].par, lane_res[0].par ^ lane_res[1].par,
                 bucket};

  assign up_ready = !skid_v_r;
  assign up_fire  = up_valid && up_ready;
  assign out_free = !out_v_r || out_tready;

  // Output register fed from the skid slot first, then from upstream
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (out_free) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = up_fire;
        out_d_nxt = hint;
      end
    end else if (up_fire) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = hint;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

`default_nettype wire
